/* hdl/gsc_pkg.sv */
`default_nettype none

package gsc_pkg;

  localparam int CNT_W  = 13;                   // cell counts, columns, rows
  localparam int DIM_W  = 14;                   // area dimensions in pixels
  localparam int ERR_W  = 27;                   // |W*rows - H*cols|
  localparam int TOT_W  = 2 * CNT_W;            // cols * rows
  localparam int PROD_W = ERR_W + CNT_W;        // shared multiplier result
  localparam int STEP_W = 4;                    // divider step counter

  localparam logic [CNT_W-1:0]  MAX_CELLS = CNT_W'(4096);
  localparam logic [DIM_W-1:0]  MAX_DIM   = DIM_W'(8192);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(CNT_W - 1);

  // mode and status codes of the item fields
  localparam logic MODE_NEAR      = 1'b0;
  localparam logic MODE_EXACT     = 1'b1;
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0] target_count;
    logic [DIM_W-1:0] area_width;
    logic [DIM_W-1:0] area_height;
    logic             mode;
  } req_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] grid_cols;
    logic [CNT_W-1:0] grid_rows;
    logic [CNT_W-1:0] total_cells;
    logic             status;
  } rsp_item_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SQ,
    S_SQ_TEST,
    S_DIV_INIT,
    S_DIV,
    S_CAND,
    S_NR_MUL,
    S_NR_TEST,
    S_MUL_WR,
    S_MUL_HC,
    S_ERR,
    S_MUL_LHS,
    S_MUL_RHS,
    S_MUL_TOT,
    S_DECIDE,
    S_NEXT,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

/* hdl/grid_shape_chooser_core.sv */
`default_nettype none

// Grid shape chooser: takes a target cell count, an area width and height and a
// mode, and returns the column and row counts whose cells come closest to
// square, judged by |W*rows - H*cols| / (H*cols) compared exactly through
// cross products. Exact mode (mode = 1) tries divisor pairs d x n/d of the count,
// each in both orientations; near mode (mode = 0) tries every column count with
// rows rounded up and breaks ties by the smaller total. A zero or out-of-range
// input gives status 1 with zero fields. One item at a time: req_ready is high
// only while the sequencer is idle, and a finished result waits in the output
// register so the next item can be taken before it is read. All work runs
// through one registered 27x13 multiplier and a one-bit-per-cycle divider under
// a small sequencer. Near mode lowers the row count for each column count while
// one less row still covers the count. Exact mode divides by each d with
// d*d <= target_count and scores each pair that divides evenly. An invalid item
// goes straight to the finish state.

module grid_shape_chooser_core (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 req_valid,
  output logic                req_ready,
  input  wire gsc_pkg::req_item_t req,
  output logic                rsp_valid,
  input  wire                 rsp_ready,
  output gsc_pkg::rsp_item_t  rsp
);

  gsc_pkg::state_t state, state_next;

  // latched item
  logic [gsc_pkg::CNT_W-1:0]  n;
  logic [gsc_pkg::DIM_W-1:0]  w;
  logic [gsc_pkg::DIM_W-1:0]  h;
  logic                       exact;
  logic                       bad;

  // candidate and loop control
  logic [gsc_pkg::CNT_W-1:0]  k;          // column count (near) or divisor (exact)
  logic [gsc_pkg::CNT_W-1:0]  cols;
  logic [gsc_pkg::CNT_W-1:0]  rows;
  logic                       orient;     // exact mode: swapped pair under test

  // divider
  logic [gsc_pkg::CNT_W-1:0]  rem;
  logic [gsc_pkg::CNT_W-1:0]  quo;
  logic [gsc_pkg::STEP_W-1:0] step;
  logic [gsc_pkg::CNT_W:0]    div_trial;
  logic                       div_ge;

  // shared multiplier and error path
  logic [gsc_pkg::ERR_W-1:0]  mul_a;
  logic [gsc_pkg::CNT_W-1:0]  mul_b;
  logic [gsc_pkg::PROD_W-1:0] prod;
  logic [gsc_pkg::ERR_W-1:0]  p1;
  logic [gsc_pkg::ERR_W-1:0]  err;
  logic [gsc_pkg::PROD_W-1:0] lhs;
  logic [gsc_pkg::PROD_W-1:0] rhs;

  // best so far
  logic                       have_best;
  logic [gsc_pkg::CNT_W-1:0]  best_cols;
  logic [gsc_pkg::CNT_W-1:0]  best_rows;
  logic [gsc_pkg::ERR_W-1:0]  best_err;
  logic [gsc_pkg::TOT_W-1:0]  best_tot;

  logic                       req_fire;
  logic                       req_bad;
  logic                       take;
  logic                       rsp_load;

  assign req_fire = req_valid && req_ready;

  assign req_bad = (req.target_count == '0) || (req.target_count > gsc_pkg::MAX_CELLS) ||
                   (req.area_width == '0)   || (req.area_width > gsc_pkg::MAX_DIM) ||
                   (req.area_height == '0)  || (req.area_height > gsc_pkg::MAX_DIM);

  // restoring divider, one quotient bit per cycle
  assign div_trial = {rem, quo[gsc_pkg::CNT_W-1]};
  assign div_ge    = div_trial >= {1'b0, k};

  // first candidate, strictly better error, or equal error and smaller total in near mode
  assign take = !have_best || (lhs < rhs) ||
                ((lhs == rhs) && !exact && (prod[gsc_pkg::TOT_W-1:0] < best_tot));

  assign rsp_load = (state == gsc_pkg::S_FINISH) && (!rsp_valid || rsp_ready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      gsc_pkg::S_IDLE: begin
        if (req_fire) begin
          if (req_bad) begin
            state_next = gsc_pkg::S_FINISH;
          end else if (req.mode == gsc_pkg::MODE_EXACT) begin
            state_next = gsc_pkg::S_SQ;
          end else begin
            state_next = gsc_pkg::S_NR_MUL;
          end
        end
      end
      gsc_pkg::S_SQ:       state_next = gsc_pkg::S_SQ_TEST;
      gsc_pkg::S_SQ_TEST: begin
        if (prod > gsc_pkg::PROD_W'(n)) begin
          state_next = gsc_pkg::S_FINISH;
        end else begin
          state_next = gsc_pkg::S_DIV_INIT;
        end
      end
      gsc_pkg::S_DIV_INIT: state_next = gsc_pkg::S_DIV;
      gsc_pkg::S_DIV: begin
        if (step == gsc_pkg::DIV_LAST) begin
          state_next = gsc_pkg::S_CAND;
        end
      end
      gsc_pkg::S_CAND: begin
        if (rem != '0) begin
          state_next = gsc_pkg::S_NEXT;
        end else begin
          state_next = gsc_pkg::S_MUL_WR;
        end
      end
      gsc_pkg::S_NR_MUL:   state_next = gsc_pkg::S_NR_TEST;
      gsc_pkg::S_NR_TEST: begin
        if (prod >= gsc_pkg::PROD_W'(n)) begin
          state_next = gsc_pkg::S_NR_MUL;
        end else begin
          state_next = gsc_pkg::S_MUL_WR;
        end
      end
      gsc_pkg::S_MUL_WR:   state_next = gsc_pkg::S_MUL_HC;
      gsc_pkg::S_MUL_HC:   state_next = gsc_pkg::S_ERR;
      gsc_pkg::S_ERR:      state_next = gsc_pkg::S_MUL_LHS;
      gsc_pkg::S_MUL_LHS:  state_next = gsc_pkg::S_MUL_RHS;
      gsc_pkg::S_MUL_RHS:  state_next = gsc_pkg::S_MUL_TOT;
      gsc_pkg::S_MUL_TOT:  state_next = gsc_pkg::S_DECIDE;
      gsc_pkg::S_DECIDE: begin
        if (exact && !orient) begin
          state_next = gsc_pkg::S_MUL_WR;
        end else begin
          state_next = gsc_pkg::S_NEXT;
        end
      end
      gsc_pkg::S_NEXT: begin
        if (exact) begin
          state_next = gsc_pkg::S_SQ;
        end else if (k == n) begin
          state_next = gsc_pkg::S_FINISH;
        end else begin
          state_next = gsc_pkg::S_NR_MUL;
        end
      end
      gsc_pkg::S_FINISH: begin
        if (rsp_load) begin
          state_next = gsc_pkg::S_IDLE;
        end
      end
      default:             state_next = gsc_pkg::S_IDLE;
    endcase
  end

  // outputs: handshake and multiplier operand select
  always_comb begin
    req_ready = (state == gsc_pkg::S_IDLE);
    mul_a     = '0;
    mul_b     = '0;
    case (state)
      gsc_pkg::S_SQ: begin
        mul_a = gsc_pkg::ERR_W'(k);
        mul_b = k;
      end
      gsc_pkg::S_NR_MUL: begin
        mul_a = gsc_pkg::ERR_W'(cols);
        mul_b = rows - gsc_pkg::CNT_W'(1);
      end
      gsc_pkg::S_MUL_WR: begin
        mul_a = gsc_pkg::ERR_W'(w);
        mul_b = rows;
      end
      gsc_pkg::S_MUL_HC: begin
        mul_a = gsc_pkg::ERR_W'(h);
        mul_b = cols;
      end
      gsc_pkg::S_MUL_LHS: begin
        mul_a = err;
        mul_b = best_cols;
      end
      gsc_pkg::S_MUL_RHS: begin
        mul_a = best_err;
        mul_b = cols;
      end
      gsc_pkg::S_MUL_TOT: begin
        mul_a = gsc_pkg::ERR_W'(cols);
        mul_b = rows;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gsc_pkg::S_IDLE;
      have_best <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (req_fire) begin
        have_best <= 1'b0;
      end else if (state == gsc_pkg::S_DECIDE && take) begin
        have_best <= 1'b1;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= gsc_pkg::PROD_W'(mul_a) * gsc_pkg::PROD_W'(mul_b);
    case (state)
      gsc_pkg::S_IDLE: begin
        if (req_fire) begin
          n      <= req.target_count;
          w      <= req.area_width;
          h      <= req.area_height;
          exact  <= (req.mode == gsc_pkg::MODE_EXACT);
          bad    <= req_bad;
          k      <= gsc_pkg::CNT_W'(1);
          cols   <= gsc_pkg::CNT_W'(1);
          rows   <= req.target_count;   // ceil(n / 1)
          orient <= 1'b0;
        end
      end
      gsc_pkg::S_DIV_INIT: begin
        rem  <= '0;
        quo  <= n;
        step <= '0;
      end
      gsc_pkg::S_DIV: begin
        rem  <= div_ge ? gsc_pkg::CNT_W'(div_trial - {1'b0, k})
                       : div_trial[gsc_pkg::CNT_W-1:0];
        quo  <= {quo[gsc_pkg::CNT_W-2:0], div_ge};
        step <= step + gsc_pkg::STEP_W'(1);
      end
      gsc_pkg::S_CAND: begin
        cols   <= k;
        rows   <= quo;
        orient <= 1'b0;
      end
      gsc_pkg::S_NR_TEST: begin
        // rows still covers n with one less row: step down
        if (prod >= gsc_pkg::PROD_W'(n)) begin
          rows <= rows - gsc_pkg::CNT_W'(1);
        end
      end
      gsc_pkg::S_MUL_HC: begin
        p1 <= prod[gsc_pkg::ERR_W-1:0];
      end
      gsc_pkg::S_ERR: begin
        err <= (p1 > prod[gsc_pkg::ERR_W-1:0]) ? p1 - prod[gsc_pkg::ERR_W-1:0]
                                               : prod[gsc_pkg::ERR_W-1:0] - p1;
      end
      gsc_pkg::S_MUL_RHS: begin
        lhs <= prod;
      end
      gsc_pkg::S_MUL_TOT: begin
        rhs <= prod;
      end
      gsc_pkg::S_DECIDE: begin
        if (take) begin
          best_cols <= cols;
          best_rows <= rows;
          best_err  <= err;
          best_tot  <= prod[gsc_pkg::TOT_W-1:0];
        end
        // exact mode: offer the swapped pair next
        if (exact && !orient) begin
          cols   <= rows;
          rows   <= cols;
          orient <= 1'b1;
        end
      end
      gsc_pkg::S_NEXT: begin
        k    <= k + gsc_pkg::CNT_W'(1);
        cols <= k + gsc_pkg::CNT_W'(1);
      end
      default: begin
      end
    endcase
    if (rsp_load) begin
      if (bad || !have_best) begin
        rsp.grid_cols   <= '0;
        rsp.grid_rows   <= '0;
        rsp.total_cells <= '0;
        rsp.status      <= gsc_pkg::STATUS_INVALID;
      end else begin
        rsp.grid_cols   <= best_cols;
        rsp.grid_rows   <= best_rows;
        rsp.total_cells <= best_tot[gsc_pkg::CNT_W-1:0];
        rsp.status      <= gsc_pkg::STATUS_OK;
      end
    end
  end

`ifndef SYNTHESIS
  // near mode rows are the rounded-up quotient once the row search settles
  a_near_rows_ceil: assert property (@(posedge clk) disable iff (rst)
    (state == gsc_pkg::S_MUL_WR && !exact && !bad) |->
      ((gsc_pkg::TOT_W'(cols) * gsc_pkg::TOT_W'(rows) >= gsc_pkg::TOT_W'(n)) &&
       (gsc_pkg::TOT_W'(cols) * gsc_pkg::TOT_W'(rows - gsc_pkg::CNT_W'(1)) <
        gsc_pkg::TOT_W'(n))))
    else $error("near mode row count is not ceil(n / cols)");

  // divider remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == gsc_pkg::S_CAND) |-> (rem < k))
    else $error("divider remainder not below divisor");

  // a chosen grid reports its own cell count
  a_rsp_total: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status == gsc_pkg::STATUS_OK)) |->
      (rsp.total_cells ==
       gsc_pkg::CNT_W'(gsc_pkg::TOT_W'(rsp.grid_cols) * gsc_pkg::TOT_W'(rsp.grid_rows))))
    else $error("total_cells does not match grid_cols * grid_rows");

  // a result leaves the output register only when taken
  a_rsp_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(rsp_valid) |-> $past(rsp_ready))
    else $error("result dropped without handshake");
`endif

endmodule

`default_nettype wire
